// ----- rtl/lcc_pkg.sv -----
// ----------------------------------------------------------------------------
// lcc_pkg: shared types and constants of the Lab color classifier
// Class codes, register indexes, reset values and the transaction structs
// that travel on the ports.
// ----------------------------------------------------------------------------
package lcc_pkg;

    // Field widths fixed by the interface.
    localparam int CLS_W      = 3;
    localparam int IDX_W      = 4;
    localparam int VOTE_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Weighted distance: 3*255^2 + 255^2 needs 18 bits.
    localparam int DIST_W     = 18;

    // Number of references and of votable classes.
    localparam int NUM_REFS   = 3;
    localparam int NUM_COLORS = 5;

    // Queue between the classifier and the vote unit (power of two).
    localparam int QUEUE_DEPTH = 2;

    // Defaults of the top-level parameters.
    localparam int DEF_SAMPLES_PER_BURST = 5;
    localparam int DEF_SKIPPED_SAMPLES   = 1;

    // Class codes.
    localparam logic [CLS_W-1:0] CLS_UNKNOWN = 3'd0;
    localparam logic [CLS_W-1:0] CLS_RED     = 3'd1;
    localparam logic [CLS_W-1:0] CLS_GREEN   = 3'd2;
    localparam logic [CLS_W-1:0] CLS_BLUE    = 3'd3;
    localparam logic [CLS_W-1:0] CLS_WHITE   = 3'd4;
    localparam logic [CLS_W-1:0] CLS_BLACK   = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RED_REF     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_REF   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_REF    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WHITE_L_MIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WHITE_B_MAX = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BLACK_MIN   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_VOTES_NEED  = 3'd7;

    // Register reset values.
    localparam logic [15:0]       RST_RED_REF     = 16'd43148;
    localparam logic [15:0]       RST_GREEN_REF   = 16'd24975;
    localparam logic [15:0]       RST_BLUE_REF    = 16'd32088;
    localparam logic [7:0]        RST_TOLERANCE   = 8'd30;
    localparam logic [7:0]        RST_WHITE_L_MIN = 8'd89;
    localparam logic [7:0]        RST_WHITE_B_MAX = 8'd40;
    localparam logic [7:0]        RST_BLACK_MIN   = 8'd100;
    localparam logic [VOTE_W-1:0] RST_VOTES_NEED  = 4'd2;

    localparam logic [VOTE_W-1:0] VOTE_MAX = '1;

    // One input transaction.
    typedef struct packed {
        logic [7:0] black_ratio;
        logic [7:0] lightness;
        logic [7:0] lab_a;
        logic [7:0] lab_b;
        logic       sample_ok;
    } in_item_t;

    // One result transaction.
    typedef struct packed {
        logic [CLS_W-1:0] sample_class;
        logic             burst_done;
        logic [CLS_W-1:0] dominant_color;
    } out_item_t;

    // Configuration register file contents.
    typedef struct packed {
        logic [15:0]       red_ref;
        logic [15:0]       green_ref;
        logic [15:0]       blue_ref;
        logic [7:0]        tolerance;
        logic [7:0]        white_light_min;
        logic [7:0]        white_b_max;
        logic [7:0]        black_min;
        logic [VOTE_W-1:0] votes_needed;
    } cfg_t;

endpackage

// ----- rtl/lcc_classify.sv -----
// ----------------------------------------------------------------------------
// lcc_classify: front part, per-sample color classification
// Stage one computes the three weighted distances, the squared tolerance and
// the white and black tests; stage two picks the class from those registers.
// ----------------------------------------------------------------------------
module lcc_classify
    import lcc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  cfg_t             cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [CLS_W-1:0] out_class
);

    // Weighted squared distance of (a, b) to a reference; heavy_b selects
    // the dA^2 + 3*dB^2 form, otherwise 3*dA^2 + dB^2.
    function automatic logic [DIST_W-1:0] wdist(
        input logic [7:0]  a,
        input logic [7:0]  b,
        input logic [15:0] refv,
        input logic        heavy_b
    );
        logic [7:0]        ra;
        logic [7:0]        rb;
        logic [7:0]        da;
        logic [7:0]        db;
        logic [15:0]       sa;
        logic [15:0]       sb;
        logic [DIST_W-1:0] wa;
        logic [DIST_W-1:0] wb;
        ra = refv[15:8];
        rb = refv[7:0];
        da = (a >= ra) ? (a - ra) : (ra - a);
        db = (b >= rb) ? (b - rb) : (rb - b);
        sa = {8'd0, da} * {8'd0, da};
        sb = {8'd0, db} * {8'd0, db};
        wa = heavy_b ? DIST_W'(sa) : (DIST_W'(sa) << 1) + DIST_W'(sa);
        wb = heavy_b ? (DIST_W'(sb) << 1) + DIST_W'(sb) : DIST_W'(sb);
        return wa + wb;
    endfunction

    logic              st_valid_reg;
    logic              st_valid_next;
    logic [DIST_W-1:0] dist_reg [NUM_REFS];
    logic [15:0]       tol_sq_reg;
    logic              white_reg;
    logic              black_reg;
    logic              ok_reg;
    logic              load;
    logic              push;
    logic [DIST_W-1:0] best_d;
    logic [CLS_W-1:0]  best;

    // Stage register handshake: refill whenever the held transaction leaves.
    assign push     = st_valid_reg && out_ready;
    assign in_ready = !st_valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb begin
        st_valid_next = st_valid_reg;
        if (load) begin
            st_valid_next = 1'b1;
        end else if (push) begin
            st_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else begin
            st_valid_reg <= st_valid_next;
        end
    end

    // Stage one: distances and threshold tests.
    always_ff @(posedge aclk) begin
        if (load) begin
            dist_reg[0] <= wdist(in_item.lab_a, in_item.lab_b, cfg.red_ref, 1'b0);
            dist_reg[1] <= wdist(in_item.lab_a, in_item.lab_b, cfg.green_ref, 1'b0);
            dist_reg[2] <= wdist(in_item.lab_a, in_item.lab_b, cfg.blue_ref, 1'b1);
            tol_sq_reg  <= {8'd0, cfg.tolerance} * {8'd0, cfg.tolerance};
            white_reg   <= (in_item.lightness >= cfg.white_light_min) &&
                           (in_item.black_ratio <= cfg.white_b_max);
            black_reg   <= in_item.black_ratio >= cfg.black_min;
            ok_reg      <= in_item.sample_ok;
        end
    end

    // Stage two: nearest matching reference, the earlier one on a tie.
    always_comb begin
        best_d = '1;
        best   = CLS_UNKNOWN;
        for (int i = 0; i < NUM_REFS; i++) begin
            if ((dist_reg[i] <= DIST_W'(tol_sq_reg)) && (dist_reg[i] < best_d)) begin
                best_d = dist_reg[i];
                best   = CLS_W'(i + 1);
            end
        end
    end

    // Invalid samples give unknown; otherwise fall back to white, then black, when no reference matches.
    always_comb begin
        if (!ok_reg) begin
            out_class = CLS_UNKNOWN;
        end else if (best != CLS_UNKNOWN) begin
            out_class = best;
        end else if (white_reg) begin
            out_class = CLS_WHITE;
        end else if (black_reg) begin
            out_class = CLS_BLACK;
        end else begin
            out_class = CLS_UNKNOWN;
        end
    end

    assign out_valid = st_valid_reg;

endmodule

// ----- rtl/lcc_fifo.sv -----
// ----------------------------------------------------------------------------
// lcc_fifo: short class queue between the front and back parts
// Holds classified samples so the classifier and the vote unit stall
// independently of each other.
// ----------------------------------------------------------------------------
module lcc_fifo
    import lcc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [CLS_W-1:0] in_class,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [CLS_W-1:0] out_class
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CLS_W-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             wr;
    logic             rd;

    assign in_ready  = count_reg != CNT_W'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_class = mem_reg[rd_ptr_reg];
    assign wr        = in_valid && in_ready;
    assign rd        = out_valid && out_ready;

    // Pointer and fill count update; pointers wrap at the power-of-two depth.
    always_comb begin
        wr_ptr_next = wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (wr && !rd) begin
            count_next = count_reg + 1'b1;
        end else if (rd && !wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage.
    always_ff @(posedge aclk) begin
        if (wr) begin
            mem_reg[wr_ptr_reg] <= in_class;
        end
    end

endmodule

// ----- rtl/lcc_vote.sv -----
// ----------------------------------------------------------------------------
// lcc_vote: back part, burst position, vote counting and verdict
// Counts votes per class over a burst, picks the dominant color on the last
// sample and holds each result transaction in an output register.
// ----------------------------------------------------------------------------
module lcc_vote
    import lcc_pkg::*;
#(
    parameter int SAMPLES_PER_BURST = DEF_SAMPLES_PER_BURST,
    parameter int SKIPPED_SAMPLES   = DEF_SKIPPED_SAMPLES
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [VOTE_W-1:0] votes_needed,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CLS_W-1:0]  in_class,
    output logic              out_valid,
    input  logic              out_ready,
    output out_item_t         out_data
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLES_PER_BURST - 1);
    localparam logic [IDX_W-1:0] SKIP_IDX = IDX_W'(SKIPPED_SAMPLES);

    logic              out_valid_reg;
    logic              out_valid_next;
    out_item_t         out_data_reg;
    out_item_t         out_data_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic [VOTE_W-1:0] votes_reg  [NUM_COLORS];
    logic [VOTE_W-1:0] votes_next [NUM_COLORS];
    logic [VOTE_W-1:0] votes_upd  [NUM_COLORS];
    logic [VOTE_W-1:0] maxc;
    logic [CLS_W-1:0]  dom;
    logic [CLS_W-1:0]  verdict;
    logic              take;
    logic              is_last;
    logic              cast;

    assign in_ready = !out_valid_reg || out_ready;
    assign take     = in_valid && in_ready;
    assign is_last  = idx_reg >= LAST_IDX;
    assign cast     = (in_class != CLS_UNKNOWN) && (idx_reg >= SKIP_IDX);

    // Counts including this sample's vote, saturating at the top.
    always_comb begin
        for (int k = 0; k < NUM_COLORS; k++) begin
            votes_upd[k] = votes_reg[k];
            if (cast && (in_class == CLS_W'(k + 1)) && (votes_reg[k] != VOTE_MAX)) begin
                votes_upd[k] = votes_reg[k] + 1'b1;
            end
        end
    end

    // Highest count, lowest class code on a tie.
    always_comb begin
        maxc = '0;
        dom  = CLS_UNKNOWN;
        for (int k = 0; k < NUM_COLORS; k++) begin
            if (votes_upd[k] > maxc) begin
                maxc = votes_upd[k];
                dom  = CLS_W'(k + 1);
            end
        end
        verdict = (maxc >= votes_needed) ? dom : CLS_UNKNOWN;
    end

    // Next state: advance the burst, clear the votes on its last sample.
    always_comb begin
        idx_next       = idx_reg;
        votes_next     = votes_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (take) begin
            idx_next                     = is_last ? '0 : idx_reg + 1'b1;
            out_valid_next               = 1'b1;
            out_data_next.sample_class   = in_class;
            out_data_next.burst_done     = is_last;
            out_data_next.dominant_color = is_last ? verdict : CLS_UNKNOWN;
            for (int k = 0; k < NUM_COLORS; k++) begin
                votes_next[k] = is_last ? '0 : votes_upd[k];
            end
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            for (int k = 0; k < NUM_COLORS; k++) begin
                votes_reg[k] <= '0;
            end
        end else begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            votes_reg     <= votes_next;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- rtl/lab_color_classifier_vote.sv -----
// ----------------------------------------------------------------------------
// lab_color_classifier_vote: Lab color classifier with burst voting
// Classifies each camera sample against red, green and blue references and
// the white and black thresholds, and gives a voted color per burst.
// ----------------------------------------------------------------------------
//
//   Channel  Ports                        Direction  Contents
//   s_       s_valid, s_ready, s_data     in         one sample (in_item_t)
//   m_       m_valid, m_ready, m_data     out        one result (out_item_t)
//   cfg_     cfg_wr_en, cfg_index, ...    in         register write, no wait
//
// One transaction per cycle sustained while m_ready stays high; an s_ accept
// loads the distance stage, the class queue takes the class from it and the
// vote output register takes it from the queue, after which m_valid rises.
// The rate is set by the distance stage: six 8x8 distance squares and the tolerance square side by side.
// Reset is synchronous on aresetn low: registers take their reset values,
// the burst position and all vote counts clear.
// A stall on m_ready fills the output register, then the two-entry queue,
// then the distance stage, after which s_ready drops.
//
module lab_color_classifier_vote
    import lcc_pkg::*;
#(
    parameter int SAMPLES_PER_BURST = DEF_SAMPLES_PER_BURST,
    parameter int SKIPPED_SAMPLES   = DEF_SKIPPED_SAMPLES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    logic             q_in_valid;
    logic             q_in_ready;
    logic [CLS_W-1:0] q_in_class;
    logic             q_out_valid;
    logic             q_out_ready;
    logic [CLS_W-1:0] q_out_class;

    // Configuration register writes.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_RED_REF:     cfg_next.red_ref         = cfg_wr_data;
                REG_GREEN_REF:   cfg_next.green_ref       = cfg_wr_data;
                REG_BLUE_REF:    cfg_next.blue_ref        = cfg_wr_data;
                REG_TOLERANCE:   cfg_next.tolerance       = cfg_wr_data[7:0];
                REG_WHITE_L_MIN: cfg_next.white_light_min = cfg_wr_data[7:0];
                REG_WHITE_B_MAX: cfg_next.white_b_max     = cfg_wr_data[7:0];
                REG_BLACK_MIN:   cfg_next.black_min       = cfg_wr_data[7:0];
                REG_VOTES_NEED:  cfg_next.votes_needed    = cfg_wr_data[VOTE_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.red_ref         <= RST_RED_REF;
            cfg_reg.green_ref       <= RST_GREEN_REF;
            cfg_reg.blue_ref        <= RST_BLUE_REF;
            cfg_reg.tolerance       <= RST_TOLERANCE;
            cfg_reg.white_light_min <= RST_WHITE_L_MIN;
            cfg_reg.white_b_max     <= RST_WHITE_B_MAX;
            cfg_reg.black_min       <= RST_BLACK_MIN;
            cfg_reg.votes_needed    <= RST_VOTES_NEED;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: classification.
    lcc_classify u_classify (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (s_data),
        .out_valid (q_in_valid),
        .out_ready (q_in_ready),
        .out_class (q_in_class)
    );

    // Queue between front and back.
    lcc_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_class  (q_in_class),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_class (q_out_class)
    );

    // Back: burst voting and result register.
    lcc_vote #(
        .SAMPLES_PER_BURST (SAMPLES_PER_BURST),
        .SKIPPED_SAMPLES   (SKIPPED_SAMPLES)
    ) u_vote (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .votes_needed (cfg_reg.votes_needed),
        .in_valid     (q_out_valid),
        .in_ready     (q_out_ready),
        .in_class     (q_out_class),
        .out_valid    (m_valid),
        .out_ready    (m_ready),
        .out_data     (m_data)
    );

    // A verdict only appears on the last sample of a burst.
    a_verdict_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.burst_done |-> m_data.dominant_color == CLS_UNKNOWN)
        else $error("dominant color given outside the end of a burst");

    // Result codes stay within the class encoding.
    a_codes_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.sample_class <= CLS_BLACK) &&
                    (m_data.dominant_color <= CLS_BLACK))
        else $error("result carries an undefined class code");

    // Reset empties the pipeline and opens the input.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("pipeline not empty after reset");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for lab_color_classifier_vote
// Drives camera samples through the valid/ready input channel and checks
// every result transaction against a cycle-free model of the classifier and
// the burst vote. The run steps through several register settings and
// several idle and stall patterns, including one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
    import lcc_pkg::*;

    localparam int BURST_LEN    = DEF_SAMPLES_PER_BURST;
    localparam int SKIP_LEN     = DEF_SKIPPED_SAMPLES;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 20;
    // Larger than any weighted distance of 8-bit channels.
    localparam int NO_MATCH     = 1 << 30;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    in_item_t              s_data      = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    out_item_t             m_data;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    // Stimulus and checking state.
    in_item_t  pending_samples[$];
    out_item_t expected_results[$];
    int        errors      = 0;
    int        send_idle   = 0;
    int        recv_stall  = 0;
    logic      s_taken     = 1'b0;
    logic      stall_hold  = 1'b0;
    event      hold_go;

    // Model copy of the registers, burst position and vote counts.
    cfg_t              cfg_model = '{red_ref: RST_RED_REF, green_ref: RST_GREEN_REF,
                                     blue_ref: RST_BLUE_REF, tolerance: RST_TOLERANCE,
                                     white_light_min: RST_WHITE_L_MIN,
                                     white_b_max: RST_WHITE_B_MAX,
                                     black_min: RST_BLACK_MIN,
                                     votes_needed: RST_VOTES_NEED};
    logic [IDX_W-1:0]  burst_pos = '0;
    logic [VOTE_W-1:0] vote_count [1:NUM_COLORS] = '{default: '0};

    lab_color_classifier_vote #(
        .SAMPLES_PER_BURST(BURST_LEN),
        .SKIPPED_SAMPLES  (SKIP_LEN)
    ) u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data)
    );

    // Clock.
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Run limit.
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // Nearest matching reference, then the white and black thresholds.
    function automatic logic [CLS_W-1:0] classify_sample(in_item_t x);
        logic [15:0]      refv;
        logic [CLS_W-1:0] best;
        int               da, db, d, best_d, tol_sq;
        logic [CLS_W-1:0] ref_cls [NUM_REFS] = '{CLS_RED, CLS_GREEN, CLS_BLUE};
        if (!x.sample_ok) begin
            return CLS_UNKNOWN;
        end
        tol_sq = int'(cfg_model.tolerance) * int'(cfg_model.tolerance);
        best_d = NO_MATCH;
        best   = CLS_UNKNOWN;
        for (int i = 0; i < NUM_REFS; i++) begin
            refv = (i == 0) ? cfg_model.red_ref :
                   (i == 1) ? cfg_model.green_ref : cfg_model.blue_ref;
            da = int'(x.lab_a) - int'(refv[15:8]);
            db = int'(x.lab_b) - int'(refv[7:0]);
            // Blue weighs the B channel, red and green the A channel.
            d = (ref_cls[i] == CLS_BLUE) ? da * da + 3 * db * db : 3 * da * da + db * db;
            if (d <= tol_sq && d < best_d) begin
                best_d = d;
                best   = ref_cls[i];
            end
        end
        if (best != CLS_UNKNOWN) begin
            return best;
        end
        if (x.lightness >= cfg_model.white_light_min &&
            x.black_ratio <= cfg_model.white_b_max) begin
            return CLS_WHITE;
        end
        if (x.black_ratio >= cfg_model.black_min) begin
            return CLS_BLACK;
        end
        return CLS_UNKNOWN;
    endfunction

    // Result of one accepted sample; advances the burst position and votes.
    function automatic out_item_t predict_result(in_item_t x);
        out_item_t         r;
        logic [VOTE_W-1:0] maxc;
        logic [CLS_W-1:0]  dom;
        r.sample_class   = classify_sample(x);
        r.burst_done     = 1'b0;
        r.dominant_color = CLS_UNKNOWN;
        if (r.sample_class != CLS_UNKNOWN && int'(burst_pos) >= SKIP_LEN) begin
            if (vote_count[r.sample_class] != VOTE_MAX) begin
                vote_count[r.sample_class]++;
            end
        end
        if (int'(burst_pos) + 1 >= BURST_LEN) begin
            // Highest count wins; the lower color code keeps a tie.
            maxc = '0;
            dom  = CLS_UNKNOWN;
            for (int c = 1; c <= NUM_COLORS; c++) begin
                if (vote_count[c] > maxc) begin
                    maxc = vote_count[c];
                    dom  = 3'(c);
                end
            end
            r.burst_done     = 1'b1;
            r.dominant_color = (maxc >= cfg_model.votes_needed) ? dom : CLS_UNKNOWN;
            burst_pos        = '0;
            for (int c = 1; c <= NUM_COLORS; c++) begin
                vote_count[c] = '0;
            end
        end else begin
            burst_pos = burst_pos + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [7:0] clip_byte(int v);
        if (v < 0) begin
            return 8'd0;
        end
        if (v > 255) begin
            return 8'd255;
        end
        return 8'(v);
    endfunction

    // One random sample aimed at a class; unknown means fully random.
    function automatic in_item_t random_sample(logic [CLS_W-1:0] target);
        in_item_t    x;
        logic [15:0] refv;
        int          spread;
        x.black_ratio = 8'($urandom_range(255));
        x.lightness   = 8'($urandom_range(255));
        x.lab_a       = 8'($urandom_range(255));
        x.lab_b       = 8'($urandom_range(255));
        x.sample_ok   = ($urandom_range(15) != 0);
        case (target)
            CLS_RED, CLS_GREEN, CLS_BLUE: begin
                refv = (target == CLS_RED) ? cfg_model.red_ref :
                       (target == CLS_GREEN) ? cfg_model.green_ref : cfg_model.blue_ref;
                spread  = $urandom_range(24);
                x.lab_a = clip_byte(int'(refv[15:8]) + int'($urandom_range(2 * spread)) - spread);
                x.lab_b = clip_byte(int'(refv[7:0]) + int'($urandom_range(2 * spread)) - spread);
            end
            CLS_WHITE: begin
                x.lightness   = 8'($urandom_range(cfg_model.white_light_min, 255));
                x.black_ratio = 8'($urandom_range(0, cfg_model.white_b_max));
            end
            CLS_BLACK: begin
                x.black_ratio = 8'($urandom_range(cfg_model.black_min, 255));
            end
            default: begin
                x.sample_ok = 1'($urandom_range(1));
            end
        endcase
        return x;
    endfunction

    // Whole bursts, most samples aimed at one class so that verdicts form.
    task automatic queue_bursts(int count);
        logic [CLS_W-1:0] target, kind;
        for (int n = 0; n < count; n++) begin
            target = 3'($urandom_range(CLS_BLACK));
            for (int k = 0; k < BURST_LEN; k++) begin
                kind = ($urandom_range(99) < 70) ? target : 3'($urandom_range(CLS_BLACK));
                pending_samples.push_back(random_sample(kind));
            end
        end
    endtask

    task automatic add_sample(logic [7:0] blk, logic [7:0] lgt, logic [7:0] a,
                              logic [7:0] b, logic ok);
        in_item_t x;
        x.black_ratio = blk;
        x.lightness   = lgt;
        x.lab_a       = a;
        x.lab_b       = b;
        x.sample_ok   = ok;
        pending_samples.push_back(x);
    endtask

    // Register write; the block is idle whenever this is called.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        case (idx)
            REG_RED_REF:     cfg_model.red_ref         = value;
            REG_GREEN_REF:   cfg_model.green_ref       = value;
            REG_BLUE_REF:    cfg_model.blue_ref        = value;
            REG_TOLERANCE:   cfg_model.tolerance       = value[7:0];
            REG_WHITE_L_MIN: cfg_model.white_light_min = value[7:0];
            REG_WHITE_B_MAX: cfg_model.white_b_max     = value[7:0];
            REG_BLACK_MIN:   cfg_model.black_min       = value[7:0];
            default:         cfg_model.votes_needed    = value[VOTE_W-1:0];
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic program_regs(logic [15:0] red, logic [15:0] green, logic [15:0] blue,
                                logic [7:0] tol, logic [7:0] wl, logic [7:0] wb,
                                logic [7:0] bm, logic [VOTE_W-1:0] vn);
        write_reg(REG_RED_REF, red);
        write_reg(REG_GREEN_REF, green);
        write_reg(REG_BLUE_REF, blue);
        write_reg(REG_TOLERANCE, {8'd0, tol});
        write_reg(REG_WHITE_L_MIN, {8'd0, wl});
        write_reg(REG_WHITE_B_MAX, {8'd0, wb});
        write_reg(REG_BLACK_MIN, {8'd0, bm});
        write_reg(REG_VOTES_NEED, {12'd0, vn});
    endtask

    // Wait until every queued sample is taken and every result has come back.
    task automatic drain();
        while (pending_samples.size() != 0 || s_valid || expected_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Input driver: a new transaction once the previous one was taken.
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || s_taken)) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle) begin
                s_data  <= pending_samples.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Output back-pressure, random or held off for a long stretch.
    always @(negedge aclk) begin
        m_ready <= !stall_hold && ($urandom_range(99) >= recv_stall);
    end

    // Long hold-off, counted here so the sender keeps running meanwhile.
    always @(hold_go) begin
        stall_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        stall_hold = 1'b0;
    end

    // Monitor: check each result, then predict for each accepted sample.
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no sample pending: %p", m_data);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.sample_class !== want.sample_class) begin
                        $error("sample_class: expected %0d, got %0d",
                               want.sample_class, m_data.sample_class);
                        errors++;
                    end
                    if (m_data.burst_done !== want.burst_done) begin
                        $error("burst_done: expected %0d, got %0d",
                               want.burst_done, m_data.burst_done);
                        errors++;
                    end
                    if (m_data.dominant_color !== want.dominant_color) begin
                        $error("dominant_color: expected %0d, got %0d",
                               want.dominant_color, m_data.dominant_color);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_result(s_data));
            end
        end
        s_taken <= s_valid && s_ready;
    end

    // Test sequence.
    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed bursts at the reset settings, no idling.
        // Invalid samples and exact reference hits: red wins the burst.
        add_sample(8'd0, 8'd0, 8'd168, 8'd140, 1'b0);
        add_sample(8'd0, 8'd0, 8'd168, 8'd140, 1'b1);
        add_sample(8'd10, 8'd50, 8'd168, 8'd140, 1'b1);
        add_sample(8'd0, 8'd0, 8'd97, 8'd143, 1'b1);
        add_sample(8'd255, 8'd255, 8'd97, 8'd143, 1'b0);
        // Field extremes, white and black at their thresholds, red at the tolerance edge.
        add_sample(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
        add_sample(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
        add_sample(8'd40, 8'd89, 8'd128, 8'd128, 1'b1);
        add_sample(8'd100, 8'd0, 8'd128, 8'd128, 1'b1);
        add_sample(8'd0, 8'd0, 8'd168, 8'd170, 1'b1);
        // Blue inside and just outside the tolerance, red just outside.
        add_sample(8'd0, 8'd0, 8'd125, 8'd88, 1'b1);
        add_sample(8'd0, 8'd0, 8'd168, 8'd171, 1'b1);
        add_sample(8'd0, 8'd0, 8'd125, 8'd88, 1'b1);
        add_sample(8'd0, 8'd0, 8'd125, 8'd105, 1'b1);
        add_sample(8'd0, 8'd0, 8'd125, 8'd106, 1'b1);
        // Red and green tie on votes: red wins.
        add_sample(8'd255, 8'd0, 8'd128, 8'd128, 1'b1);
        add_sample(8'd0, 8'd0, 8'd168, 8'd140, 1'b1);
        add_sample(8'd0, 8'd0, 8'd97, 8'd143, 1'b1);
        add_sample(8'd0, 8'd0, 8'd168, 8'd140, 1'b1);
        add_sample(8'd0, 8'd0, 8'd97, 8'd143, 1'b1);
        // Blue and white tie on votes: blue wins.
        add_sample(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        add_sample(8'd0, 8'd0, 8'd125, 8'd88, 1'b1);
        add_sample(8'd0, 8'd200, 8'd128, 8'd128, 1'b1);
        add_sample(8'd0, 8'd0, 8'd125, 8'd88, 1'b1);
        add_sample(8'd40, 8'd89, 8'd128, 8'd128, 1'b1);
        drain();

        // Random bursts at the reset settings.
        queue_bursts(60);
        drain();

        // Widest tolerance, loosest white and strictest black thresholds, random references; sender idles.
        program_regs(16'($urandom), 16'($urandom), 16'($urandom),
                     8'd255, 8'd0, 8'd255, 8'd255, 4'd1);
        send_idle = 86;
        queue_bursts(60);
        drain();

        // Zero tolerance, corner references, a verdict that cannot be reached;
        // receiver stalls.
        program_regs(16'h0000, 16'hFFFF, 16'h8080, 8'd0, 8'd255, 8'd0, 8'd0, 4'd15);
        send_idle  = 0;
        recv_stall = 86;
        queue_bursts(60);
        drain();

        // Identical references so red and green distances tie; zero votes needed.
        // Starts with a long output hold-off while the sender keeps pushing.
        program_regs(16'h8080, 16'h8080, 16'h8080, 8'd20, 8'd60, 8'd80, 8'd120, 4'd0);
        recv_stall = 0;
        -> hold_go;
        queue_bursts(20);
        drain();
        send_idle  = 12;
        recv_stall = 12;
        queue_bursts(40);
        drain();

        // Reset references with random thresholds; light idling, then none.
        program_regs(RST_RED_REF, RST_GREEN_REF, RST_BLUE_REF, 8'($urandom),
                     8'($urandom), 8'($urandom), 8'($urandom), 4'd3);
        queue_bursts(40);
        drain();
        send_idle  = 0;
        recv_stall = 0;
        queue_bursts(20);
        drain();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/lcc_pkg.sv
rtl/lcc_classify.sv
rtl/lcc_fifo.sv
rtl/lcc_vote.sv
rtl/lab_color_classifier_vote.sv
tb/sv/testbench.sv
